// ===== rtl/mcst_pkg.sv =====
// Package for the multi-channel slew-limited servo target block.
// Holds widths, command and status codes, register indexes and payload types.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mcst_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int REPORT_FIELDS = 6;
	localparam int CHAN_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int POS_W = 12;
	localparam int DEG_W = 8;
	localparam int INTERVAL_W = 10;
	localparam int STEP_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [DEG_W-1:0] RESET_TARGET_DEG = 8'd90;
	localparam logic [POS_W-1:0] RESET_POSITION = 12'd1440;
	localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 10'd15;
	localparam logic [STEP_W-1:0] RESET_STEP = 12'd8;
	localparam logic [INTERVAL_W-1:0] COUNT_MAX = 10'd1023;
	localparam logic [15:0] MAX_ANGLE_DEG = 16'd180;

	// Command kinds.
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SET = 2'd1;
	localparam logic [1:0] KIND_GET = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_REPORT = 2'd0;
	localparam logic [1:0] STAT_SET_OK = 2'd1;
	localparam logic [1:0] STAT_SET_BAD = 2'd2;
	localparam logic [1:0] STAT_UNKNOWN = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [7:0] channel;
		logic signed [15:0] angle;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] echo_channel;
		logic [7:0] pos0;
		logic [7:0] pos1;
		logic [7:0] pos2;
		logic [7:0] pos3;
		logic [7:0] pos4;
		logic [7:0] pos5;
	} rsp_item_t;

	typedef struct packed {
		logic [POS_W-1:0] next_pos;
		logic moving;
	} lane_result_t;

	// Position in sixteenths rounded half up to whole degrees.
	function automatic logic [DEG_W-1:0] round_deg(input logic [POS_W-1:0] pos);
		logic [POS_W:0] sum;
		sum = {1'b0, pos} + (POS_W+1)'(8);
		return sum[POS_W-1:4];
	endfunction

endpackage

// ===== rtl/mcst_if.sv =====
// Handshake interfaces for the servo target block: command, response, configuration.
// Depends on mcst_pkg for payload types and widths.
`timescale 1ns / 1ps

interface mcst_cmd_if;
	logic valid;
	logic ready;
	mcst_pkg::cmd_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mcst_rsp_if;
	logic valid;
	logic ready;
	mcst_pkg::rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mcst_cfg_if;
	logic valid;
	logic ready;
	logic [mcst_pkg::CFG_IDX_W-1:0] index;
	logic [mcst_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mcst_slew_lane.sv =====
// One channel's slew step: distance to target, dead band, clamp to the step size.
// Depends on mcst_pkg for widths and the lane result type.
`timescale 1ns / 1ps

module mcst_slew_lane (
	input  logic [mcst_pkg::POS_W-1:0]  cur_pos,
	input  logic [mcst_pkg::DEG_W-1:0]  target_deg,
	input  logic [mcst_pkg::STEP_W-1:0] max_step,
	output mcst_pkg::lane_result_t      result
);

	localparam int DW = mcst_pkg::POS_W + 2;

	logic signed [DW-1:0] tgt_s;
	logic signed [DW-1:0] cur_s;
	logic signed [DW-1:0] step_s;
	logic signed [DW-1:0] diff;
	logic signed [DW-1:0] mag;
	logic signed [DW-1:0] delta;
	logic signed [DW-1:0] sum;

	always_comb begin
		tgt_s = signed'(DW'({target_deg, 4'b0000}));
		cur_s = signed'(DW'(cur_pos));
		step_s = signed'(DW'(max_step));
		diff = tgt_s - cur_s;
		mag = diff[DW-1] ? -diff : diff;
		if (diff > step_s) begin
			delta = step_s;
		end else if (diff < -step_s) begin
			delta = -step_s;
		end else begin
			delta = diff;
		end
		sum = cur_s + delta;
		// A distance of one sixteenth or less counts as arrived.
		result.moving = (mag >= DW'(2));
		result.next_pos = result.moving ? sum[mcst_pkg::POS_W-1:0] : cur_pos;
	end

endmodule

// ===== rtl/multi_channel_slew_limited_servo_targets.sv =====
// Top level of the multi-channel slew-limited servo target block.
// Depends on mcst_pkg, the interfaces in mcst_if and the mcst_slew_lane module.
`timescale 1ns / 1ps

// The block keeps a target angle in whole degrees and a current position in
// sixteenths of a degree for each servo channel, all at ninety degrees after
// reset. A command transaction is accepted in every cycle in which the response
// register is empty or is being emptied, and its response, if any, is loaded
// into that register on the edge that accepts the command. The sustained rate
// is one transaction per cycle, set only by the response register and the
// downstream ready. Set commands answer with an acknowledge or an error, get
// commands and unknown commands always answer, and ticks answer only when a
// slew update moved at least one channel. Configuration writes are always ready
// and take effect on the next transaction; writes to an index past the second
// register are ignored.

module multi_channel_slew_limited_servo_targets (
	input  logic              clk,
	input  logic              arst_n,
	mcst_cmd_if.sink          cmd,
	mcst_rsp_if.source        rsp,
	mcst_cfg_if.sink          cfg
);

	localparam int NCH = mcst_pkg::NUM_CHANNELS;

	// Configuration registers.
	logic [mcst_pkg::INTERVAL_W-1:0] interval_q;
	logic [mcst_pkg::STEP_W-1:0]     max_step_q;

	// Channel state and the millisecond counter.
	logic [mcst_pkg::POS_W-1:0]      pos_q [NCH];
	logic [mcst_pkg::DEG_W-1:0]      tgt_q [NCH];
	logic [mcst_pkg::INTERVAL_W-1:0] ms_q;

	// Response register.
	logic                rsp_valid_q;
	mcst_pkg::rsp_item_t rsp_q;

	mcst_pkg::lane_result_t lane_res [NCH];
	logic [NCH-1:0]         lane_moving;

	logic                            cmd_fire;
	logic [mcst_pkg::INTERVAL_W:0]   cnt_inc;
	logic [mcst_pkg::INTERVAL_W-1:0] cnt_sat;
	logic                            tick_update;
	logic                            set_ok;
	logic [mcst_pkg::CHAN_W-1:0]     set_idx;
	logic                            has_result;
	logic [mcst_pkg::DEG_W-1:0]      rep_deg [mcst_pkg::REPORT_FIELDS];
	mcst_pkg::rsp_item_t             rsp_d;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire = cmd.valid && cmd.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// The six slew computations run in parallel on the stored state.
	for (genvar i = 0; i < NCH; i++) begin : g_lane
		mcst_slew_lane u_lane (
			.cur_pos    (pos_q[i]),
			.target_deg (tgt_q[i]),
			.max_step   (max_step_q),
			.result     (lane_res[i])
		);
		assign lane_moving[i] = lane_res[i].moving;
	end

	// Report fields: a tick reports the freshly updated positions, a get
	// reports the stored ones. Fields without a channel read zero.
	for (genvar j = 0; j < mcst_pkg::REPORT_FIELDS; j++) begin : g_rep
		if (j < NCH) begin : g_has
			assign rep_deg[j] = (cmd.data.kind == mcst_pkg::KIND_TICK)
				? mcst_pkg::round_deg(lane_res[j].next_pos)
				: mcst_pkg::round_deg(pos_q[j]);
		end else begin : g_none
			assign rep_deg[j] = '0;
		end
	end

	always_comb begin
		// The counter saturates rather than wrapping; an interval of zero
		// updates on every tick.
		cnt_inc = {1'b0, ms_q} + (mcst_pkg::INTERVAL_W+1)'(1);
		cnt_sat = cnt_inc[mcst_pkg::INTERVAL_W] ? mcst_pkg::COUNT_MAX
			: cnt_inc[mcst_pkg::INTERVAL_W-1:0];
		tick_update = (cnt_sat >= interval_q);

		set_ok = !cmd.data.channel[7]
			&& (unsigned'(cmd.data.channel) < 8'(NCH))
			&& !cmd.data.angle[15]
			&& (unsigned'(cmd.data.angle) <= mcst_pkg::MAX_ANGLE_DEG);
		set_idx = cmd.data.channel[mcst_pkg::CHAN_W-1:0];

		rsp_d = '0;
		has_result = 1'b1;
		case (cmd.data.kind)
			mcst_pkg::KIND_TICK: begin
				has_result = tick_update && (|lane_moving);
				rsp_d.status = mcst_pkg::STAT_REPORT;
			end
			mcst_pkg::KIND_SET: begin
				if (set_ok) begin
					rsp_d.status = mcst_pkg::STAT_SET_OK;
					rsp_d.echo_channel = cmd.data.channel[2:0];
				end else begin
					rsp_d.status = mcst_pkg::STAT_SET_BAD;
				end
			end
			mcst_pkg::KIND_GET: begin
				rsp_d.status = mcst_pkg::STAT_REPORT;
			end
			default: begin
				rsp_d.status = mcst_pkg::STAT_UNKNOWN;
			end
		endcase

		if (cmd.data.kind == mcst_pkg::KIND_TICK || cmd.data.kind == mcst_pkg::KIND_GET) begin
			rsp_d.pos0 = rep_deg[0];
			rsp_d.pos1 = rep_deg[1];
			rsp_d.pos2 = rep_deg[2];
			rsp_d.pos3 = rep_deg[3];
			rsp_d.pos4 = rep_deg[4];
			rsp_d.pos5 = rep_deg[5];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= mcst_pkg::RESET_INTERVAL;
			max_step_q <= mcst_pkg::RESET_STEP;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				mcst_pkg::CFG_UPDATE_INTERVAL: begin
					interval_q <= cfg.data[mcst_pkg::INTERVAL_W-1:0];
				end
				mcst_pkg::CFG_MAX_STEP: begin
					max_step_q <= cfg.data[mcst_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Millisecond counter: clears when an update runs, else counts each tick, saturating.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
		end else if (cmd_fire && cmd.data.kind == mcst_pkg::KIND_TICK) begin
			ms_q <= tick_update ? '0 : cnt_sat;
		end
	end

	// Per-channel position and target registers.
	for (genvar i = 0; i < NCH; i++) begin : g_state
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q[i] <= mcst_pkg::RESET_POSITION;
				tgt_q[i] <= mcst_pkg::RESET_TARGET_DEG;
			end else if (cmd_fire) begin
				if (cmd.data.kind == mcst_pkg::KIND_TICK && tick_update) begin
					pos_q[i] <= lane_res[i].next_pos;
				end
				if (cmd.data.kind == mcst_pkg::KIND_SET && set_ok
					&& set_idx == mcst_pkg::CHAN_W'(i)) begin
					tgt_q[i] <= cmd.data.angle[mcst_pkg::DEG_W-1:0];
				end
			end
		end
	end

	// Response register: loads on any transaction that yields a response and
	// empties when downstream takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_fire && has_result) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire && has_result) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
